FILE: rtl/tcsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsf_pkg: shared types, constants and tables of the tone-curve sharpen filter
// Holds the register map, the command that travels from the front end to the
// back end, the tone-curve table and the line-store rotation helpers.
// ----------------------------------------------------------------------------
package tcsf_pkg;

	// Pixel and register widths.
	localparam int PIX_W          = 8;
	localparam int IMAGE_WIDTH_W  = 13;
	localparam int IMAGE_HEIGHT_W = 16;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	// Register values after reset.
	localparam logic [IMAGE_WIDTH_W-1:0]  RESET_WIDTH  = 13'd640;
	localparam logic [IMAGE_HEIGHT_W-1:0] RESET_HEIGHT = 16'd480;

	// Item kinds on the input tuser bit.
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// Default line length limit and depth of the command queue.
	localparam int MAX_WIDTH_DEFAULT = 4096;
	localparam int QUEUE_DEPTH       = 4;
	localparam int NUM_STORES        = 3;

	// Command for one item, without the column addresses.
	typedef struct packed {
		logic             wr_en;     // write the curved pixel into the current store
		logic             emit;      // the item produces a result
		logic             drain;     // lower neighbor is the center row itself
		logic             first_col; // left neighbor is the center itself
		logic             up_pp;     // upper neighbor comes from the row before last
		logic [1:0]       rot;       // store that receives the current row
		logic [PIX_W-1:0] tone;      // curved input pixel
		logic             eor;
		logic             eof;
	} cmd_t;

	// Tone curve: largest t with t^5 * 2^32 <= v^9, found by a binary search.
	function automatic logic [256*PIX_W-1:0] build_tone_rom();
		logic [256*PIX_W-1:0] rom;
		logic [79:0]          v9;
		logic [79:0]          c5;
		logic [7:0]           t;
		logic [7:0]           cand;
		rom = '0;
		for (int v = 0; v < 256; v++) begin
			v9 = 80'(v);
			for (int k = 1; k < 9; k++) begin
				v9 = v9 * 80'(v);
			end
			t = '0;
			for (int b = 7; b >= 0; b--) begin
				cand = t | 8'(1 << b);
				c5 = 80'(cand);
				for (int k = 1; k < 5; k++) begin
					c5 = c5 * 80'(cand);
				end
				c5 = c5 << 32;
				if (c5 <= v9) begin
					t = cand;
				end
			end
			rom[v*PIX_W +: PIX_W] = t;
		end
		return rom;
	endfunction

	localparam logic [256*PIX_W-1:0] TONE_ROM = build_tone_rom();

	// Store that follows in the rotation.
	function automatic logic [1:0] next_rot(input logic [1:0] rot);
		return (rot == 2'd2) ? 2'd0 : rot + 2'd1;
	endfunction

	// Store holding the previous row (rotation + 2).
	function automatic logic [1:0] prv_index(input logic [1:0] rot);
		return (rot == 2'd0) ? 2'd2 : rot - 2'd1;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/tcsf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsf_queue: command queue between front end and back end
// A small register FIFO; each side stalls on its own through full and empty.
// ----------------------------------------------------------------------------
module tcsf_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = tcsf_pkg::QUEUE_DEPTH,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              full,
	output logic              empty
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW:0]       count_q;

	// Status from the fill count.
	assign full  = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// The fill count rises on each push that comes without a pop.
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not rise on push");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue pushed while full or popped while empty");

endmodule
`default_nettype wire

FILE: rtl/tcsf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsf_front: item intake and classification
// Holds the frame registers and the raster position, maps pixels through the
// tone curve and turns each accepted item that fits the frame into a back-end command.
// ----------------------------------------------------------------------------
module tcsf_front #(
	parameter int MAX_WIDTH = tcsf_pkg::MAX_WIDTH_DEFAULT,
	localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int XW1      = XW + 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tcsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tcsf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tcsf_pkg::PIX_W-1:0]         s_axis_tdata,
	input  logic                               s_axis_tuser,
	input  logic                               q_full,
	output logic                               push,
	output tcsf_pkg::cmd_t                     cmd,
	output logic [XW-1:0]                      x,
	output logic [XW-1:0]                      xr
);

	logic [tcsf_pkg::IMAGE_WIDTH_W-1:0]  width_q;
	logic [tcsf_pkg::IMAGE_HEIGHT_W-1:0] height_q;
	logic [XW-1:0]                       col_q;
	logic [XW-1:0]                       dcol_q;
	logic [tcsf_pkg::IMAGE_HEIGHT_W-1:0] row_q;
	logic [1:0]                          rot_q;

	logic [XW1-1:0]                      eff_w;
	logic [tcsf_pkg::IMAGE_HEIGHT_W-1:0] eff_h;
	logic                                accept;
	logic                                is_drain;
	logic                                pix_ok;
	logic                                drn_ok;
	logic [XW-1:0]                       pos;
	logic [XW1-1:0]                      pos_inc;
	logic                                last;

	// Width and height as used: zero acts as one, width is capped.
	always_comb begin
		if (width_q == '0) begin
			eff_w = XW1'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = XW1'(MAX_WIDTH);
		end else begin
			eff_w = XW1'(width_q);
		end
		eff_h = (height_q == '0) ? tcsf_pkg::IMAGE_HEIGHT_W'(1) : height_q;
	end

	// Classify the item against the raster position.
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_drain      = (s_axis_tuser == tcsf_pkg::FUNC_DRAIN);
	assign pix_ok        = !is_drain && (row_q < eff_h) && (XW1'(col_q) < eff_w);
	assign drn_ok        = is_drain && (row_q >= eff_h) && (XW1'(dcol_q) < eff_w);
	assign pos           = is_drain ? dcol_q : col_q;
	assign pos_inc       = XW1'(pos) + XW1'(1);
	assign last          = (pos_inc == eff_w);
	assign push          = accept && (pix_ok || drn_ok);

	// Command fields and column addresses, right edge repeated.
	always_comb begin
		x             = pos;
		xr            = (pos_inc < eff_w) ? pos_inc[XW-1:0] : pos;
		cmd.wr_en     = !is_drain;
		cmd.emit      = is_drain || (row_q != '0);
		cmd.drain     = is_drain;
		cmd.first_col = (pos == '0);
		cmd.up_pp     = is_drain ? (eff_h >= tcsf_pkg::IMAGE_HEIGHT_W'(2))
		                         : (row_q >= tcsf_pkg::IMAGE_HEIGHT_W'(2));
		cmd.rot       = rot_q;
		cmd.tone      = tcsf_pkg::TONE_ROM[{s_axis_tdata, 3'b000} +: tcsf_pkg::PIX_W];
		cmd.eor       = last;
		cmd.eof       = is_drain && last;
	end

	// Frame registers and raster position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tcsf_pkg::RESET_WIDTH;
			height_q <= tcsf_pkg::RESET_HEIGHT;
			col_q    <= '0;
			dcol_q   <= '0;
			row_q    <= '0;
			rot_q    <= '0;
		end else if (cfg_we) begin
			priority if (cfg_index == tcsf_pkg::CFG_IMAGE_WIDTH) begin
				width_q <= cfg_wdata[tcsf_pkg::IMAGE_WIDTH_W-1:0];
				col_q   <= '0;
				dcol_q  <= '0;
				row_q   <= '0;
			end else if (cfg_index == tcsf_pkg::CFG_IMAGE_HEIGHT) begin
				height_q <= cfg_wdata[tcsf_pkg::IMAGE_HEIGHT_W-1:0];
				col_q    <= '0;
				dcol_q   <= '0;
				row_q    <= '0;
			end else begin
				width_q <= width_q;
			end
		end else if (push) begin
			if (!is_drain) begin
				if (last) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
					rot_q <= tcsf_pkg::next_rot(rot_q);
				end else begin
					col_q <= pos_inc[XW-1:0];
				end
			end else begin
				if (last) begin
					dcol_q <= '0;
					row_q  <= '0;
					col_q  <= '0;
				end else begin
					dcol_q <= pos_inc[XW-1:0];
				end
			end
		end
	end

	// An item that is dropped leaves the raster position alone.
	a_drop_keeps_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !push && !cfg_we) |=>
		($stable(row_q) && $stable(col_q) && $stable(dcol_q) && $stable(rot_q)))
		else $error("dropped item moved the raster position");

	a_eof_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd.eof) |-> (cmd.drain && cmd.eor && !cmd.wr_en))
		else $error("frame end flagged on a non-drain item");

endmodule
`default_nettype wire

FILE: rtl/tcsf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsf_back: line stores and sharpen datapath
// Pops commands, writes curved pixels into the three rotating line stores,
// reads the stencil taps and registers the clamped result for the output.
// ----------------------------------------------------------------------------
module tcsf_back #(
	parameter int MAX_WIDTH = tcsf_pkg::MAX_WIDTH_DEFAULT,
	localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  tcsf_pkg::cmd_t               q_cmd,
	input  logic [XW-1:0]                q_x,
	input  logic [XW-1:0]                q_xr,
	output logic                         pop,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [tcsf_pkg::PIX_W-1:0]   m_axis_tdata,  // [7:0] pixel_out
	output logic                         m_axis_tlast,  // end_of_row
	output logic                         m_axis_tuser   // end_of_frame
);

	localparam int PW = tcsf_pkg::PIX_W;

	logic              advance;
	logic              valid_s1;
	tcsf_pkg::cmd_t    cmd_s1;
	logic [PW-1:0]     rd_lo_s1 [tcsf_pkg::NUM_STORES];
	logic [PW-1:0]     rd_hi_s1 [tcsf_pkg::NUM_STORES];

	logic [1:0]        prv_idx;
	logic [1:0]        pp_idx;
	logic [PW-1:0]     center;
	logic [PW-1:0]     right;
	logic [PW-1:0]     upper;
	logic [PW-1:0]     lower;
	logic [PW-1:0]     left;
	logic [11:0]       center9;
	logic [9:0]        nsum;
	logic signed [12:0] sharp;
	logic [PW-1:0]     clamped;

	logic [PW-1:0]     left_q;
	logic              out_valid_q;
	logic [PW-1:0]     pix_out_q;
	logic              eor_q;
	logic              eof_q;

	// The whole back end moves when the output register is free or drained.
	assign advance = !out_valid_q || m_axis_tready;
	assign pop     = advance && !q_empty;

	// Three line stores, one write and two registered reads each.
	for (genvar i = 0; i < tcsf_pkg::NUM_STORES; i++) begin : g_store
		logic [PW-1:0] mem [MAX_WIDTH];
		logic [PW-1:0] lo_s1;
		logic [PW-1:0] hi_s1;

		always_ff @(posedge clk) begin
			if (pop && q_cmd.wr_en && (q_cmd.rot == 2'(i))) begin
				mem[q_x] <= q_cmd.tone;
			end
			if (pop) begin
				lo_s1 <= mem[q_x];
				hi_s1 <= mem[q_xr];
			end
		end

		assign rd_lo_s1[i] = lo_s1;
		assign rd_hi_s1[i] = hi_s1;
	end

	// Stencil taps: previous row is the center row, the one before is above.
	always_comb begin
		prv_idx = tcsf_pkg::prv_index(cmd_s1.rot);
		pp_idx  = tcsf_pkg::next_rot(cmd_s1.rot);
		center  = rd_lo_s1[prv_idx];
		right   = rd_hi_s1[prv_idx];
		upper   = cmd_s1.up_pp ? rd_lo_s1[pp_idx] : center;
		lower   = cmd_s1.drain ? center : cmd_s1.tone;
		left    = cmd_s1.first_col ? center : left_q;
	end

	// Sharpen: 9*c - 2*(l + r + u + d), clamped to the pixel range.
	always_comb begin
		center9 = {1'b0, center, 3'b000} + 12'(center);
		nsum    = 10'(left) + 10'(right) + 10'(upper) + 10'(lower);
		sharp   = $signed({1'b0, center9}) - $signed({2'b00, nsum, 1'b0});
		if (sharp < 13'sd0) begin
			clamped = '0;
		end else if (sharp > 13'sd255) begin
			clamped = '1;
		end else begin
			clamped = sharp[PW-1:0];
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			out_valid_q <= valid_s1 && cmd_s1.emit;
		end
	end

	// Pipeline payload and left-neighbor register.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= q_cmd;
		end
		if (advance && valid_s1 && cmd_s1.emit) begin
			pix_out_q <= clamped;
			eor_q     <= cmd_s1.eor;
			eof_q     <= cmd_s1.eof;
			left_q    <= center;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = pix_out_q;
	assign m_axis_tlast  = eor_q;
	assign m_axis_tuser  = eof_q;

	// A stalled output freezes the read stage behind it.
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> ($stable(valid_s1) && $stable(cmd_s1)))
		else $error("read stage moved under a stalled output");

	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("frame end without row end");

endmodule
`default_nettype wire

FILE: rtl/tone_curve_sharpen_filter_top.sv
`default_nettype none
// A result leaves through the command queue, the store read and the output register.
// Throughput: one item per cycle, sustained while the output side takes results.
// The rate is set by the registered stencil read from the line stores.
// A 4-entry command queue lets intake continue while a result waits.
// Reset clears positions and registers (width 640, height 480); the line
// stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// tone_curve_sharpen_filter_top: tone curve and 3x3 cross sharpen, streaming
// Front end classifies pixel and drain items, a queue decouples it from the
// back end that owns the line stores and produces the sharpened pixels.
// ----------------------------------------------------------------------------
module tone_curve_sharpen_filter_top #(
	parameter int MAX_WIDTH = tcsf_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tcsf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tcsf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tcsf_pkg::PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel_in
	input  logic                             s_axis_tuser,  // func
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tcsf_pkg::PIX_W-1:0]       m_axis_tdata,  // [7:0] pixel_out
	output logic                             m_axis_tlast,  // end_of_row
	output logic                             m_axis_tuser   // end_of_frame
);

	localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMD_W  = $bits(tcsf_pkg::cmd_t);
	localparam int DATA_W = CMD_W + 2 * XW;

	logic              f_push;
	tcsf_pkg::cmd_t    f_cmd;
	logic [XW-1:0]     f_x;
	logic [XW-1:0]     f_xr;
	logic              q_full;
	logic              q_empty;
	logic              b_pop;
	logic [DATA_W-1:0] q_wdata;
	logic [DATA_W-1:0] q_rdata;
	tcsf_pkg::cmd_t    b_cmd;
	logic [XW-1:0]     b_x;
	logic [XW-1:0]     b_xr;

	// Item intake.
	tcsf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_full       (q_full),
		.push         (f_push),
		.cmd          (f_cmd),
		.x            (f_x),
		.xr           (f_xr)
	);

	// Command queue.
	assign q_wdata = {f_x, f_xr, f_cmd};

	tcsf_queue #(
		.DATA_W(DATA_W),
		.DEPTH (tcsf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata (q_wdata),
		.pop   (b_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	assign b_cmd = q_rdata[CMD_W-1:0];
	assign b_xr  = q_rdata[CMD_W +: XW];
	assign b_x   = q_rdata[CMD_W + XW +: XW];

	// Line stores and sharpen datapath.
	tcsf_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (b_cmd),
		.q_x          (b_x),
		.q_xr         (b_xr),
		.pop          (b_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule
`default_nettype wire
